[src/assert_macros.svh]
// Assertion macros shared by the RTL of the page free stack allocator.
// Stands alone; modules that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define PFSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PFSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pfsa_pkg.sv]
// Types and constants of the page free stack allocator.
// Request and response payloads, operation and status codes, sequencer states.
// No dependencies.
package pfsa_pkg;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned FRAME_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned FREE_CNT_W  = 13;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_RGN_CALC,
    S_RGN_WALK
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  region_base;
    logic [ADDR_W-1:0]  region_length;
    logic               region_usable;
    logic [ADDR_W-1:0]  page_address;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [ADDR_W-1:0]      granted_address;
    logic [FREE_CNT_W-1:0]  free_count;
  } rsp_t;

endpackage

[src/page_free_stack_allocator.sv]
// Page free stack allocator: a last-in first-out store of free 4 KiB page frames.
// Uses pfsa_pkg for payload types and codes, and assert_macros.svh for checks.
//
// Usage:
//   Requests arrive on in_valid_i / in_stall_o carrying in_req_i; responses leave on
//   out_valid_o / out_stall_i carrying out_rsp_o, exactly one response per request.
//   A transfer happens at a clock edge where valid is high and stall is low.
//   Free pushes a page frame and answers in the cycle after acceptance, so frees
//   run back to back at one request per cycle while out_stall_i stays low.
//   Alloc reads the top entry of the frame memory into rd_data_q and answers from
//   that in S_POP; an alloc on an empty stack answers without a memory read, with
//   status empty. A new request is taken in the cycle its response leaves.
//   Add-region works out the first and the end page in S_RGN_CALC, then pushes
//   the pages into the frame memory one after another in S_RGN_WALK, then
//   finishes and loads its response. Unusable regions answer in the cycle after
//   acceptance with status ignored.
//   Pages that do not fit are dropped with status full.
//   Reset clears the page count; the frame memory needs no clearing, since only
//   entries below the count are ever read.
//   While the response register is held by out_stall_i, no request is accepted.
`include "assert_macros.svh"

module page_free_stack_allocator import pfsa_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned WW = FRAME_W + 1;
  localparam int unsigned LW = FRAME_W + 2;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [WW-1:0] walk_q, walk_d;
  logic [LW-1:0] last_q, last_d;
  logic [ADDR_W-1:0] base_q, base_d, length_q, length_d;
  logic out_valid_q;
  rsp_t rsp_q, rsp_d;
  logic rsp_load;

  logic [FRAME_W-1:0] frame_mem [STACK_DEPTH];
  logic [FRAME_W-1:0] rd_data_q;
  logic mem_we, rd_en;
  logic [AW-1:0] mem_wa, rd_addr;
  logic [FRAME_W-1:0] mem_wd;

  logic in_acc, out_free, full, pushable;
  logic [CW-1:0] count_dec;
  logic [PAGE_SHIFT:0] low_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(STACK_DEPTH));
  assign count_dec  = count_q - CW'(1);
  assign rd_addr    = count_dec[AW-1:0];
  assign pushable   = (WW'(walk_q) < last_q[WW-1:0] || last_q[LW-1]) && !walk_q[FRAME_W];
  assign low_sum    = {1'b0, base_q[PAGE_SHIFT-1:0]} + {1'b0, length_q[PAGE_SHIFT-1:0]};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    walk_d   = walk_q;
    last_d   = last_q;
    base_d   = base_q;
    length_d = length_q;
    mem_we   = 1'b0;
    mem_wa   = count_q[AW-1:0];
    mem_wd   = '0;
    rd_en    = 1'b0;
    rsp_load = 1'b0;
    rsp_d    = '0;
    rsp_d.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.kind)
            KIND_ADD: begin
              if (in_req_i.region_usable) begin
                base_d   = in_req_i.region_base;
                length_d = in_req_i.region_length;
                state_d  = S_RGN_CALC;
              end else begin
                rsp_load     = 1'b1;
                rsp_d.status = ST_IGNORED;
              end
            end
            KIND_ALLOC: begin
              if (count_q == '0) begin
                rsp_load     = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                count_d = count_dec;
                state_d = S_POP;
              end
            end
            KIND_FREE: begin
              rsp_load = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wd  = in_req_i.page_address[ADDR_W-1:PAGE_SHIFT];
                count_d = count_q + CW'(1);
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        rsp_load              = 1'b1;
        rsp_d.granted_address = {rd_data_q, {PAGE_SHIFT{1'b0}}};
        state_d               = S_IDLE;
      end
      S_RGN_CALC: begin
        walk_d  = {1'b0, base_q[ADDR_W-1:PAGE_SHIFT]}
                + WW'(base_q[PAGE_SHIFT-1:0] != '0);
        last_d  = LW'(base_q[ADDR_W-1:PAGE_SHIFT]) + LW'(length_q[ADDR_W-1:PAGE_SHIFT])
                + LW'(low_sum[PAGE_SHIFT]);
        state_d = S_RGN_WALK;
      end
      S_RGN_WALK: begin
        if (pushable && !full) begin
          mem_we  = 1'b1;
          mem_wd  = walk_q[FRAME_W-1:0];
          count_d = count_q + CW'(1);
          walk_d  = walk_q + WW'(1);
        end else begin
          rsp_load     = 1'b1;
          rsp_d.status = pushable ? ST_FULL : ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    rsp_d.free_count = FREE_CNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    base_q   <= base_d;
    length_q <= length_d;
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `PFSA_ASSERT(a_count_bound, clk_i, rst_ni, (count_q <= CW'(STACK_DEPTH)), "page count exceeds depth")
  `PFSA_ASSERT(a_no_write_full, clk_i, rst_ni, (mem_we |-> !full), "push into a full stack")
  `PFSA_ASSERT(a_pop_slot_free, clk_i, rst_ni, (state_q == S_POP |-> !out_valid_q), "pop with response register busy")
  `PFSA_ASSERT(a_alloc_reads, clk_i, rst_ni, (rd_en |=> (state_q == S_POP && $past(count_q) == count_q + CW'(1))), "alloc read without pop")

endmodule
